@@ hw/rtl/sha1md_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 digest core.
package sha1md_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned WinDepth   = 16;
  localparam int unsigned NumRounds  = 80;

  localparam logic [6:0] RoundLast  = 7'(NumRounds - 1);
  localparam logic [5:0] PosFull    = 6'd63;
  localparam logic [5:0] PosLength  = 6'd56;
  localparam logic [7:0] PadMark    = 8'h80;
  localparam logic [2:0] IdxLast    = 3'(NumWords - 1);

  // Initial chaining values, H0 in slice 0
  localparam logic [NumWords-1:0][31:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_MARK,
    BYTE_ZERO
  } byte_src_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      put_byte;
    byte_src_e byte_src;
    logic      count_byte;
    logic      push_len_hi;
    logic      push_len_lo;
    logic      load;
    logic      round;
    logic      add;
    logic      restart;
    logic [2:0] out_idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic blk_full;
    logic at_length;
    logic round_last;
  } sts_t;

  // Round constant by round number
  function automatic logic [31:0] round_const(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  // Round function by round number
  function automatic logic [31:0] round_func(input logic [6:0] t, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t >= 7'd40 && t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

@@ hw/rtl/sha1md_ctrl.sv @@
// Controller state machine: byte intake, padding, compression sequencing, digest output.
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic last_byte_i,
  input  logic empty_message_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic last_word_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_MARK,
    S_ZERO,
    S_LEN_HI,
    S_LEN_LO,
    S_OUT
  } state_e;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic [2:0] idx_q, idx_d;

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign last_word_o = (idx_q == IdxLast);

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.byte_src = BYTE_DATA;
    cmd_o.out_idx  = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (empty_message_i) begin
            state_d = S_MARK;
          end else begin
            cmd_o.put_byte   = 1'b1;
            cmd_o.count_byte = 1'b1;
            if (sts_i.blk_full) begin
              cmd_o.load = 1'b1;
              ret_d      = last_byte_i ? S_MARK : S_IDLE;
              state_d    = S_ROUND;
            end else if (last_byte_i) begin
              state_d = S_MARK;
            end
          end
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ret_q;
      end
      S_MARK: begin
        cmd_o.put_byte = 1'b1;
        cmd_o.byte_src = BYTE_MARK;
        if (sts_i.blk_full) begin
          cmd_o.load = 1'b1;
          ret_d      = S_ZERO;
          state_d    = S_ROUND;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts_i.at_length) begin
          state_d = S_LEN_HI;
        end else begin
          cmd_o.put_byte = 1'b1;
          cmd_o.byte_src = BYTE_ZERO;
          if (sts_i.blk_full) begin
            cmd_o.load = 1'b1;
            ret_d      = S_ZERO;
            state_d    = S_ROUND;
          end
        end
      end
      S_LEN_HI: begin
        cmd_o.push_len_hi = 1'b1;
        state_d = S_LEN_LO;
      end
      S_LEN_LO: begin
        cmd_o.push_len_lo = 1'b1;
        cmd_o.load        = 1'b1;
        ret_d   = S_OUT;
        state_d = S_ROUND;
      end
      S_OUT: begin
        if (out_acc) begin
          if (idx_q == IdxLast) begin
            cmd_o.restart = 1'b1;
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, return state and output index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ hw/rtl/sha1md_dp.sv @@
// Datapath: byte packing, message schedule window, round registers and chaining words.
module sha1md_dp import sha1md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [31:0] digest_word_o
);

  logic [NumWords-1:0][31:0] h_q;
  logic [31:0]               work_q [NumWords];
  logic [31:0]               win_q  [WinDepth];
  logic [23:0]               acc_q;
  logic [63:0]               cnt_q;
  logic [5:0]                pos_q;
  logic [6:0]                rc_q;

  logic [7:0]  byte_val;
  logic [31:0] sched_w, wt, tmp, push_w;
  logic        shift_en;

  // Select the byte to pack
  always_comb begin
    case (cmd_i.byte_src)
      BYTE_DATA: byte_val = data_byte_i;
      BYTE_MARK: byte_val = PadMark;
      BYTE_ZERO: byte_val = 8'h00;
      default:   byte_val = 8'h00;
    endcase
  end

  // Schedule word: replay the loaded words, then expand
  assign sched_w = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign wt      = (rc_q < 7'd16) ? win_q[0] : {sched_w[30:0], sched_w[31]};

  assign tmp = {work_q[0][26:0], work_q[0][31:27]}
             + round_func(rc_q, work_q[1], work_q[2], work_q[3])
             + work_q[4] + wt + round_const(rc_q);

  // Word entering the window
  always_comb begin
    if (cmd_i.round) begin
      push_w = wt;
    end else if (cmd_i.push_len_hi) begin
      push_w = cnt_q[63:32];
    end else if (cmd_i.push_len_lo) begin
      push_w = cnt_q[31:0];
    end else begin
      push_w = {acc_q, byte_val};
    end
  end

  assign shift_en = cmd_i.round || cmd_i.push_len_hi || cmd_i.push_len_lo ||
                    (cmd_i.put_byte && (pos_q[1:0] == 2'd3));

  assign sts_o.blk_full   = (pos_q == PosFull);
  assign sts_o.at_length  = (pos_q == PosLength);
  assign sts_o.round_last = (rc_q == RoundLast);

  assign digest_word_o = h_q[cmd_i.out_idx];

  // Shift the schedule window and pack bytes
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinDepth-1] <= push_w;
    end
    if (cmd_i.put_byte) begin
      case (pos_q[1:0])
        2'd0:    acc_q[23:16] <= byte_val;
        2'd1:    acc_q[15:8]  <= byte_val;
        2'd2:    acc_q[7:0]   <= byte_val;
        default: acc_q        <= acc_q;
      endcase
    end
  end

  // Load and advance the working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < NumWords; i++) begin
        work_q[i] <= h_q[i];
      end
    end else if (cmd_i.round) begin
      work_q[0] <= tmp;
      work_q[1] <= work_q[0];
      work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
      work_q[3] <= work_q[2];
      work_q[4] <= work_q[3];
    end
  end

  // Hold chaining words, bit count, byte position and round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= HInit;
      cnt_q <= '0;
      pos_q <= '0;
      rc_q  <= '0;
    end else begin
      if (cmd_i.restart) begin
        h_q   <= HInit;
        cnt_q <= '0;
        pos_q <= '0;
      end else begin
        if (cmd_i.add) begin
          for (int i = 0; i < NumWords; i++) begin
            h_q[i] <= h_q[i] + work_q[i];
          end
        end
        if (cmd_i.count_byte) begin
          cnt_q <= cnt_q + 64'd8;
        end
        if (cmd_i.put_byte) begin
          pos_q <= pos_q + 6'd1;
        end else if (cmd_i.push_len_hi || cmd_i.push_len_lo) begin
          pos_q <= pos_q + 6'd4;
        end
      end
      if (cmd_i.load) begin
        rc_q <= '0;
      end else if (cmd_i.round) begin
        rc_q <= rc_q + 7'd1;
      end
    end
  end

endmodule

@@ hw/rtl/sha1_message_digest_core.sv @@
// Top level of the SHA-1 message digest core: controller plus datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in      | request   | in_valid_i/in_stall_o | data_byte_i, last_byte_i, empty_message_i
//   out     | result    | out_valid_o/out_stall_i| digest_word_o, word_index_o, last_word_o
//
// The byte that fills a 64-byte block stalls intake while the block is compressed
// (80 rounds on the shared round unit, then one chaining add).
// Ending a message adds a marker byte, zero fill up to the length slot, two length
// words and one or two compressions, then shows five output words.
// in_stall_o is high from the end of a message until its fifth word is taken.
// Reset loads the initial chaining values and clears the length and byte position.
module sha1_message_digest_core import sha1md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        empty_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  cmd_t cmd;
  sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .last_byte_i     (last_byte_i),
    .empty_message_i (empty_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .last_word_o     (last_word_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  sha1md_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

  assign word_index_o = cmd.out_idx;

endmodule

@@ hw/rtl/sha1md_checker.sv @@
// Port-level checker for the SHA-1 digest core, bound to the top level.
module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // Flag the fifth word only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4)))
    else $error("last_word_o does not match word index");

  // Hold off new requests while a digest is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted during digest output");

  // Advance the index by one after each taken non-final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=>
      (out_valid_o && (word_index_o == $past(word_index_o) + 3'd1)))
    else $error("digest words out of order");

  // Drop valid and return to idle after the final word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> (!out_valid_o && !in_stall_o))
    else $error("core not idle after final digest word");

  // Keep a stalled word steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the SHA-1 message digest core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports  = 10;
  localparam int unsigned RandItems   = 370;
  localparam int unsigned MinMessages = 12;
  localparam int unsigned TailCycles  = 200;
  localparam longint unsigned TimeoutNs = 64'd30_000_000;

  localparam logic [31:0] IvH0 = 32'h67452301;
  localparam logic [31:0] IvH1 = 32'hEFCDAB89;
  localparam logic [31:0] IvH2 = 32'h98BADCFE;
  localparam logic [31:0] IvH3 = 32'h10325476;
  localparam logic [31:0] IvH4 = 32'hC3D2E1F0;
  localparam logic [31:0] KChoose = 32'h5A827999;
  localparam logic [31:0] KParA   = 32'h6ED9EBA1;
  localparam logic [31:0] KMajor  = 32'h8F1BBCDC;
  localparam logic [31:0] KParB   = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int unsigned LenSlot = 56;
  localparam int unsigned BlkBytes = 64;

  // How a message is closed
  typedef enum int {
    END_LAST,
    END_EMPTY_FLAG,
    END_BOTH_FLAGS
  } msg_end_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       empty;
    bit         drain;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        empty_msg = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha1_message_digest_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .empty_message_i(empty_msg),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .digest_word_o  (digest_word),
    .word_index_o   (word_index),
    .last_word_o    (last_word)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  logic [31:0]     hash_h [5];
  logic [31:0]     blk_w [16];
  logic [63:0]     msg_bits;
  int unsigned     fill_pos;

  byte_req_t       req_q [$];
  digest_word_t    digest_q [$];
  byte_req_t       cur_req;
  digest_word_t    mon_want;

  int unsigned n_fail = 0;
  int unsigned n_items = 0;
  int unsigned n_msgs = 0;
  int unsigned n_bytes = 0;
  int unsigned longest_msg = 0;
  int unsigned n_words_ok = 0;
  int unsigned in_gap = 0;
  int unsigned ost_gap = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  task automatic note_fail(input string msg);
    if (n_fail < MaxReports) $display("%s", msg);
    n_fail++;
  endtask

  // Mostly short gaps, a few long ones, with gap-free stretches
  function automatic int unsigned pick_gap(inout bit burst);
    int unsigned r;
    if ($urandom_range(0, 39) == 0) burst = !burst;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic restart_hash();
    hash_h[0] = IvH0;
    hash_h[1] = IvH1;
    hash_h[2] = IvH2;
    hash_h[3] = IvH3;
    hash_h[4] = IvH4;
    msg_bits = '0;
    fill_pos = 0;
  endtask

  // Run the 80 rounds on the block buffer and fold into the hash
  task automatic compress_words();
    logic [31:0] a, b, c, d, e, w, f, k, x, sum;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = blk_w[t];
      end else begin
        x = blk_w[(t - 3) & 15] ^ blk_w[(t - 8) & 15] ^ blk_w[(t - 14) & 15] ^ blk_w[t & 15];
        w = {x[30:0], x[31]};
        blk_w[t & 15] = w;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = KChoose;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = KParA;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = KMajor;
      end else begin
        f = b ^ c ^ d;
        k = KParB;
      end
      sum = {a[26:0], a[31:27]} + f + e + w + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endtask

  // Pack one byte big-endian; compress on a full block
  task automatic pack_byte(input logic [7:0] b);
    int unsigned idx;
    int unsigned sh;
    idx = fill_pos >> 2;
    sh = (3 - (fill_pos & 3)) * 8;
    if ((fill_pos & 3) == 0) blk_w[idx] = 32'(b) << sh;
    else blk_w[idx] |= 32'(b) << sh;
    fill_pos++;
    if (fill_pos == BlkBytes) begin
      compress_words();
      fill_pos = 0;
    end
  endtask

  // Advance the predictor by one accepted request
  task automatic predict_request(input byte_req_t rq);
    logic [63:0]  len;
    digest_word_t dw;
    n_items++;
    if (!rq.empty) begin
      pack_byte(rq.data);
      msg_bits += 64'd8;
      n_bytes++;
      if (!rq.last) return;
    end
    len = msg_bits;
    if ((len >> 3) > longest_msg) longest_msg = 32'(len >> 3);
    pack_byte(PadByte);
    if (fill_pos > LenSlot) begin
      while (fill_pos != 0) pack_byte(8'h00);
    end
    while (fill_pos < LenSlot) pack_byte(8'h00);
    blk_w[14] = len[63:32];
    blk_w[15] = len[31:0];
    compress_words();
    for (int i = 0; i < 5; i++) begin
      dw.word = hash_h[i];
      dw.idx = 3'(i);
      dw.last = (i == 4);
      digest_q = {digest_q, dw};
    end
    n_msgs++;
    restart_hash();
  endtask

  task automatic add_req(input logic [7:0] d, input logic lst, input logic emp,
                         input bit drn);
    byte_req_t rq;
    rq.data = d;
    rq.last = lst;
    rq.empty = emp;
    rq.drain = drn;
    req_q = {req_q, rq};
  endtask

  // Queue a message of random bytes closed in the given way
  task automatic add_message(input int unsigned len, input msg_end_e how, input bit drn);
    int unsigned nb;
    nb = (how == END_LAST) ? len - 1 : len;
    for (int i = 0; i < nb; i++) add_req(8'($urandom), 1'b0, 1'b0, drn && i == 0);
    case (how)
      END_LAST: begin
        add_req(8'($urandom), 1'b1, 1'b0, drn && nb == 0);
      end
      END_EMPTY_FLAG: begin
        add_req(8'($urandom), 1'($urandom), 1'b1, drn && nb == 0);
      end
      default: begin
        add_req(8'($urandom), 1'b1, 1'b1, drn && nb == 0);
      end
    endcase
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_request(cur_req);
      if (!(in_valid && in_stall)) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].drain && digest_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= cur_req.data;
          last_byte <= cur_req.last;
          empty_msg <= cur_req.empty;
          in_gap = pick_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          note_fail($sformatf("unexpected digest word %08h idx=%0d last=%0b",
                              digest_word, word_index, last_word));
        end else begin
          mon_want = digest_q.pop_front();
          if (digest_word !== mon_want.word || word_index !== mon_want.idx ||
              last_word !== mon_want.last) begin
            note_fail($sformatf({"digest mismatch: expected %08h idx=%0d last=%0b, ",
                                 "got %08h idx=%0d last=%0b"},
                                mon_want.word, mon_want.idx, mon_want.last,
                                digest_word, word_index, last_word));
          end else begin
            n_words_ok++;
          end
        end
      end
      if (ost_gap != 0) begin
        ost_gap--;
        out_stall <= 1'b1;
      end else begin
        ost_gap = pick_gap(out_burst);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned rand_items;
    int unsigned r;
    int unsigned len;
    int unsigned pick;
    msg_end_e    how;
    int unsigned edge_lens [6];
    edge_lens = '{55, 56, 57, 63, 64, 65};

    restart_hash();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;

    // Directed: empty message, extreme bytes, known vector, flag corner cases
    add_req(8'hA5, 1'b0, 1'b1, 1'b0);
    add_req(8'h00, 1'b1, 1'b0, 1'b0);
    add_req(8'hFF, 1'b1, 1'b0, 1'b0);
    add_req(8'h61, 1'b0, 1'b0, 1'b1);
    add_req(8'h62, 1'b0, 1'b0, 1'b0);
    add_req(8'h63, 1'b1, 1'b0, 1'b0);
    add_req(8'h11, 1'b0, 1'b0, 1'b0);
    add_req(8'h22, 1'b0, 1'b0, 1'b0);
    add_req(8'h33, 1'b0, 1'b1, 1'b0);
    add_req(8'h44, 1'b0, 1'b0, 1'b0);
    add_req(8'h99, 1'b1, 1'b1, 1'b0);
    add_req(8'hFF, 1'b1, 1'b1, 1'b0);
    add_req(8'h55, 1'b0, 1'b0, 1'b0);
    add_req(8'hAA, 1'b0, 1'b0, 1'b0);
    add_req(8'h55, 1'b0, 1'b0, 1'b0);
    add_req(8'hAA, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) add_req(8'(1 << i), i == 7, 1'b0, 1'b0);

    // Random messages: mostly short, some at the padding boundaries, a few long
    rand_items = 0;
    r = 0;
    while (rand_items < RandItems || r < MinMessages) begin
      how = END_LAST;
      if ($urandom_range(0, 99) < 5) begin
        len = 0;
        how = END_EMPTY_FLAG;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = $urandom_range(1, 20);
        end else if (pick < 80) begin
          len = edge_lens[$urandom_range(0, 5)];
        end else if (pick < 92) begin
          len = $urandom_range(21, 70);
        end else begin
          len = $urandom_range(110, 135);
        end
        case ($urandom_range(0, 9))
          0:       how = END_EMPTY_FLAG;
          1:       how = END_BOTH_FLAGS;
          default: how = END_LAST;
        endcase
      end
      add_message(len, how, r == 0 || $urandom_range(0, 7) == 0);
      rand_items += (how == END_LAST) ? len : len + 1;
      r++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_q.size() != 0 || in_valid || digest_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      note_fail($sformatf("%0d digest words never arrived", digest_q.size()));
    end

    $display("Ran %0d requests: %0d messages, %0d bytes, longest %0d bytes.",
             n_items, n_msgs, n_bytes, longest_msg);
    $display("Matched %0d digest words; %0d failures.", n_words_ok, n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d requests and %0d digest words pending",
             req_q.size(), digest_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
